// File: rtl/positional_list_store_assert.svh
// Assertion macros shared by the positional list store RTL.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PLS_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pls assertion failed");

// Next-cycle implication, checked outside reset.
`define PLS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pls assertion failed");

`endif

// File: rtl/pls_pkg.sv
// Types and constants for the positional list store.
// No dependencies; used by pls_cell and positional_list_store.
package pls_pkg;

	localparam int unsigned PLS_DEPTH = 16;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned POS_W     = 5;
	localparam int unsigned LEN_W     = 5;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_FIND   = 2'd2,
		CMD_MODIFY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Operation broadcast to the whole row of cells.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2,
		CELL_WRITE  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [POS_W-1:0]         position;
		logic signed [VAL_W-1:0]  value;
	} pls_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  read_value;
		status_t                  status;
		logic [LEN_W-1:0]         length;
	} pls_result_t;

	// idx is the 0-based position addressed by the command.
	typedef struct packed {
		cell_op_t          op;
		logic [POS_W-1:0]  idx;
		logic [VAL_W-1:0]  value;
	} cell_ctl_t;

endpackage

// File: rtl/positional_list_store.sv
// Positional list store: a bounded ordered list of 32-bit signed values addressed by
// 1-based position, built as a row of DEPTH storage cells. Each command (insert,
// remove, find, modify) is taken in one transfer and answered with one result
// transfer; the result is registered and appears the cycle after the command
// transfer. The whole row shifts at once (each cell compares its own slot
// index with the addressed position in parallel and loads from its left or right
// neighbor), so the block sustains one command per cycle, and it keeps accepting
// while a result waits as long as that result is taken in the same cycle. A bad
// position (zero, or past the end) returns status 1, a valid insert into a full list
// returns status 2; both leave the list untouched and return a zero read value.
// Slots are undefined after reset; only the entry count and rsp_valid are cleared.
// Depends on pls_pkg, pls_cell and positional_list_store_assert.svh.
module positional_list_store #(
	parameter int unsigned DEPTH = pls_pkg::PLS_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  pls_pkg::pls_item_t   req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output pls_pkg::pls_result_t rsp
);
	import pls_pkg::*;

	// Count width, and a compare width that also holds count+1 and the position.
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [CW-1:0]     count_q;
	logic              rsp_valid_q;
	pls_result_t       rsp_q;

	logic              req_fire;
	logic [XW-1:0]     cnt_x;
	logic [XW-1:0]     pos_x;
	logic              pos_zero;
	logic              range_ok;
	logic              full;
	status_t           status;
	logic [CW-1:0]     count_nxt;
	logic [XW-1:0]     len_x;
	cell_ctl_t         ctl;
	logic [VAL_W-1:0]  rd_bus;
	logic [VAL_W-1:0]  read_value;

	logic [VAL_W-1:0]  cell_data [DEPTH];
	logic [VAL_W-1:0]  cell_rd   [DEPTH];

	// A result slot frees up when it is empty or being taken this cycle.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign req_fire  = req_valid && req_ready;

	//--------------------------------------------------------------------------
	// Command check
	//--------------------------------------------------------------------------
	assign cnt_x    = XW'(count_q);
	assign pos_x    = XW'(req.position);
	assign pos_zero = (req.position == '0);
	assign full     = (cnt_x >= XW'(DEPTH));

	always_comb begin
		if (req.cmd == CMD_INSERT) begin
			range_ok = !pos_zero && (pos_x <= cnt_x + XW'(1));
		end else begin
			range_ok = !pos_zero && (pos_x <= cnt_x);
		end
		// position is checked before fullness
		if (!range_ok) begin
			status = ST_RANGE;
		end else if (req.cmd == CMD_INSERT && full) begin
			status = ST_FULL;
		end else begin
			status = ST_OK;
		end
	end

	//--------------------------------------------------------------------------
	// Row control: only a good command that transfers touches the cells
	//--------------------------------------------------------------------------
	always_comb begin
		ctl.op    = CELL_HOLD;
		ctl.idx   = req.position - POS_W'(1);
		ctl.value = req.value;
		count_nxt = count_q;
		if (req_fire && status == ST_OK) begin
			unique case (req.cmd)
				CMD_INSERT: begin
					ctl.op    = CELL_INSERT;
					count_nxt = count_q + CW'(1);
				end
				CMD_REMOVE: begin
					ctl.op    = CELL_DELETE;
					count_nxt = count_q - CW'(1);
				end
				CMD_MODIFY: ctl.op = CELL_WRITE;
				default:    ctl.op = CELL_HOLD;
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// Cell row: each cell sees its left and right neighbor
	//--------------------------------------------------------------------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] left_w;
		logic [VAL_W-1:0] right_w;

		// Edge cells loop their own value back; only a tail delete ever selects one.
		if (i == 0) begin : g_head
			assign left_w = cell_data[i];
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		pls_cell #(
			.IDX(i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i]),
			.rd    (cell_rd[i])
		);
	end

	// Read bus: at most one cell drives nonzero data.
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	assign read_value = (status == ST_OK && (req.cmd == CMD_REMOVE || req.cmd == CMD_FIND))
		? rd_bus : '0;
	assign len_x = XW'(count_nxt);

	//--------------------------------------------------------------------------
	// Count and result register
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (req_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_q.read_value <= read_value;
			rsp_q.status     <= status;
			rsp_q.length     <= len_x[LEN_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	//--------------------------------------------------------------------------
	// Assertions
	//--------------------------------------------------------------------------
`include "positional_list_store_assert.svh"

	`PLS_ASSERT_IMPLY(a_count_bound, 1'b1, XW'(count_q) <= XW'(DEPTH))
	`PLS_ASSERT_NEXT(a_insert_grows, req_fire && status == ST_OK && req.cmd == CMD_INSERT, count_q == $past(count_q) + CW'(1))
	`PLS_ASSERT_NEXT(a_error_holds, req_fire && status != ST_OK, count_q == $past(count_q))
	`PLS_ASSERT_IMPLY(a_full_length, rsp_valid_q && rsp_q.status == ST_FULL, rsp_q.length == LEN_W'(DEPTH))

endmodule

// File: rtl/pls_cell.sv
// One list slot of the positional list store cell row.
// Depends on pls_pkg.
module pls_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                      clk,
	input  pls_pkg::cell_ctl_t        ctl,
	input  logic [pls_pkg::VAL_W-1:0] left,
	input  logic [pls_pkg::VAL_W-1:0] right,
	output logic [pls_pkg::VAL_W-1:0] data,
	output logic [pls_pkg::VAL_W-1:0] rd
);
	import pls_pkg::*;

	logic [VAL_W-1:0] data_q;
	logic             at_idx;
	logic             past_idx;

	assign at_idx   = (32'(IDX) == 32'(ctl.idx));
	assign past_idx = (32'(IDX) >  32'(ctl.idx));

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (at_idx) begin
					data_q <= ctl.value;
				end else if (past_idx) begin
					data_q <= left;
				end
			end
			CELL_DELETE: begin
				if (at_idx || past_idx) begin
					data_q <= right;
				end
			end
			CELL_WRITE: begin
				if (at_idx) begin
					data_q <= ctl.value;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;
	// Only the addressed cell drives the shared read bus.
	assign rd   = at_idx ? data_q : '0;

endmodule
